FILE: design/rwwl_pkg.sv
// Shared constants, command codes and the record type of the register write wait logger.
`default_nettype none
package rwwl_pkg;

   localparam int unsigned RWWL_MAX_WAIT    = 65535;
   localparam int unsigned RWWL_QUEUE_DEPTH = 4;

   localparam logic [23:0] RWWL_LIMIT_RESET = 24'd1048576;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [7:0]  WRITE_TAG  = 8'hb4;
   localparam logic [15:0] ROM_BASE   = 16'hc000;
   localparam logic [15:0] START_REG  = 16'h4012;
   localparam logic [15:0] LENGTH_REG = 16'h4013;
   localparam logic [15:0] ROM_NONE   = 16'hffff;

   typedef struct packed {
      logic [23:0] record_number;
      logic [31:0] running_samples;
      logic [15:0] waited_samples;
      logic [31:0] operation_word;
      logic [15:0] rom_low;
      logic [15:0] rom_high;
   } record_type;

endpackage
`default_nettype wire

FILE: design/rwwl_front.sv
// Front part: accepts items, tracks wait, totals and ROM range, and builds records.
`default_nettype none
module rwwl_front
   import rwwl_pkg::*;
#(
   parameter int unsigned MAX_WAIT = RWWL_MAX_WAIT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [1:0]  command,
   input  wire logic [15:0] write_address,
   input  wire logic [7:0]  write_value,
   input  wire logic        limit_write,
   input  wire logic [23:0] limit_value,
   output logic             rec_valid,
   output record_type       rec
);

   localparam logic [15:0] MaxWaitVal = 16'(MAX_WAIT);

   logic [23:0] limit_ff,   limit_in;
   logic [15:0] pending_ff, pending_in;
   logic [31:0] total_ff,   total_in;
   logic [23:0] count_ff,   count_in;
   logic [7:0]  start_ff,   start_in;
   logic        start_seen_ff, start_seen_in;
   logic [7:0]  length_ff,  length_in;
   logic        length_seen_ff, length_seen_in;
   logic [15:0] low_ff,     low_in;
   logic [15:0] high_ff,    high_in;

   logic        room;
   logic        emit;
   logic [15:0] waited;
   logic [31:0] op_word;
   logic [15:0] rom_lo;
   logic [15:0] rom_hi;

   assign room = count_ff < limit_ff;

   always_comb begin
      pending_in     = pending_ff;
      start_in       = start_ff;
      start_seen_in  = start_seen_ff;
      length_in      = length_ff;
      length_seen_in = length_seen_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      emit           = 1'b0;
      waited         = pending_ff;
      op_word        = 32'd0;
      rom_lo         = ROM_BASE + {2'b00, start_in, 6'b000000};
      rom_hi         = rom_lo + {4'b0000, length_in, 4'b0000};
      if (accept) begin
         case (command)
            CMD_TICK: begin
               if (pending_ff >= MaxWaitVal) begin
                  pending_in = 16'd1;
                  waited     = MaxWaitVal;
                  emit       = room;
               end else begin
                  pending_in = pending_ff + 16'd1;
               end
            end
            CMD_WRITE: begin
               if (room) begin
                  emit       = 1'b1;
                  pending_in = 16'd0;
                  op_word    = {WRITE_TAG, write_address, write_value};
                  if (write_address == START_REG) begin
                     start_in      = write_value;
                     start_seen_in = 1'b1;
                  end
                  if (write_address == LENGTH_REG) begin
                     length_in      = write_value;
                     length_seen_in = 1'b1;
                  end
                  rom_lo = ROM_BASE + {2'b00, start_in, 6'b000000};
                  rom_hi = rom_lo + {4'b0000, length_in, 4'b0000};
                  if (start_seen_in && length_seen_in) begin
                     if (rom_hi > high_ff) begin
                        high_in = rom_hi;
                     end
                     if (rom_lo < low_ff) begin
                        low_in = rom_lo;
                     end
                     start_seen_in  = 1'b0;
                     length_seen_in = 1'b0;
                  end
               end
            end
            CMD_FINISH: begin
               if (room) begin
                  emit       = 1'b1;
                  pending_in = 16'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign total_in = emit ? total_ff + {16'd0, waited} : total_ff;
   assign count_in = emit ? count_ff + 24'd1 : count_ff;
   assign limit_in = limit_write ? limit_value : limit_ff;

   assign rec_valid           = emit;
   assign rec.record_number   = count_ff;
   assign rec.running_samples = total_in;
   assign rec.waited_samples  = waited;
   assign rec.operation_word  = op_word;
   assign rec.rom_low         = low_in;
   assign rec.rom_high        = high_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= RWWL_LIMIT_RESET;
         pending_ff     <= 16'd0;
         total_ff       <= 32'd0;
         count_ff       <= 24'd0;
         start_ff       <= 8'd0;
         start_seen_ff  <= 1'b0;
         length_ff      <= 8'd0;
         length_seen_ff <= 1'b0;
         low_ff         <= ROM_NONE;
         high_ff        <= 16'd0;
      end else begin
         limit_ff       <= limit_in;
         pending_ff     <= pending_in;
         total_ff       <= total_in;
         count_ff       <= count_in;
         start_ff       <= start_in;
         start_seen_ff  <= start_seen_in;
         length_ff      <= length_in;
         length_seen_ff <= length_seen_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/rwwl_queue.sv
// Short record queue between the front and back parts.
`default_nettype none
module rwwl_queue
   import rwwl_pkg::*;
#(
   parameter int unsigned DEPTH = RWWL_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire record_type  wr_data,
   output logic             q_full,
   input  wire logic        rd_en,
   output logic             q_valid,
   output record_type       rd_data
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   record_type            mem_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff,  count_in;

   assign q_full  = count_ff == FullCnt;
   assign q_valid = count_ff != '0;
   assign rd_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = !wr_en ? wr_ptr_ff :
                      (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !rd_en ? rd_ptr_ff :
                      (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/rwwl_back.sv
// Back part: holds the oldest record in an output register until it is popped.
`default_nettype none
module rwwl_back
   import rwwl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire record_type q_data,
   output logic            q_read,
   output logic            empty,
   input  wire logic       pop,
   output record_type      out_rec
);

   logic       valid_ff, valid_in;
   record_type rec_ff;
   logic       take;

   assign take     = pop && valid_ff;
   assign q_read   = q_valid && (!valid_ff || take);
   assign valid_in = q_read ? 1'b1 : (take ? 1'b0 : valid_ff);
   assign empty    = !valid_ff;
   assign out_rec  = rec_ff;

   always_ff @(posedge clock) begin
      if (q_read) begin
         rec_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/register_write_wait_logger_core.sv
// Top level of the register write wait logger: front, record queue and output stage.
//
//   Channel   Ports                                    Beat taken when
//   -------   --------------------------------------   -------------------------
//   request   push, full, req_command/address/value    push high and full low
//   response  empty, pop, rsp_* record fields          pop high and empty low
//   csr       csr_valid, csr_ready, csr_data           csr_valid and csr_ready high
//
// One request beat can be taken every clock while full is low; the front updates all its
// state when the beat is taken. A record produced by a beat is visible on the response
// ports once the record queue has stored it and the output register has loaded it.
// Reset is synchronous and active high; afterward the limit is 1048576 and all counts clear.
// The front stalls (full high) only when the record queue is full; the queue and output
// register let the response side stall, blocking request beats only once the queue fills.
`default_nettype none
module register_write_wait_logger_core
   import rwwl_pkg::*;
#(
   parameter int unsigned MAX_WAIT    = RWWL_MAX_WAIT,
   parameter int unsigned QUEUE_DEPTH = RWWL_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_write_address,
   input  wire logic [7:0]  req_write_value,
   // Response channel.
   output logic             empty,
   input  wire logic        pop,
   output logic [23:0]      rsp_record_number,
   output logic [31:0]      rsp_running_samples,
   output logic [15:0]      rsp_waited_samples,
   output logic [31:0]      rsp_operation_word,
   output logic [15:0]      rsp_rom_low,
   output logic [15:0]      rsp_rom_high,
   // Configuration channel carrying the record limit.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_data
);

   logic       accept;
   logic       rec_valid;
   record_type rec;
   logic       q_full;
   logic       q_valid;
   logic       q_read;
   record_type q_data;
   record_type out_rec;

   // The limit register can always take a write, so users must write it only while idle.
   assign csr_ready = 1'b1;

   // Every request beat may produce a record, so the queue must have room for it.
   assign full   = q_full;
   assign accept = push && !q_full;

   rwwl_front #(
      .MAX_WAIT (MAX_WAIT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .write_address (req_write_address),
      .write_value   (req_write_value),
      .limit_write   (csr_valid),
      .limit_value   (csr_data),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   rwwl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_valid),
      .wr_data (rec),
      .q_full  (q_full),
      .rd_en   (q_read),
      .q_valid (q_valid),
      .rd_data (q_data)
   );

   rwwl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_read  (q_read),
      .empty   (empty),
      .pop     (pop),
      .out_rec (out_rec)
   );

   assign rsp_record_number   = out_rec.record_number;
   assign rsp_running_samples = out_rec.running_samples;
   assign rsp_waited_samples  = out_rec.waited_samples;
   assign rsp_operation_word  = out_rec.operation_word;
   assign rsp_rom_low         = out_rec.rom_low;
   assign rsp_rom_high        = out_rec.rom_high;

endmodule
`default_nettype wire
